// ===== sv/rvalu_pkg.sv =====
// ----------------------------------------------------------------------------
// rvalu_pkg: shared types and constants for the RV32IM integer execute unit
// Operation codes, item structs and the word/stage geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package rvalu_pkg;

   localparam int unsigned WordBits = 32;
   localparam int unsigned TagBits  = 5;
   localparam int unsigned ModeBits = 5;
   // quotient bits resolved per divide cell
   localparam int unsigned DivBitsPerCell = 2;

   typedef enum logic [ModeBits-1:0] {
      OP_ADD    = 5'd0,
      OP_SUB    = 5'd1,
      OP_SLL    = 5'd2,
      OP_SLT    = 5'd3,
      OP_SLTU   = 5'd4,
      OP_XOR    = 5'd5,
      OP_OR     = 5'd6,
      OP_AND    = 5'd7,
      OP_SRL    = 5'd8,
      OP_SRA    = 5'd9,
      OP_MUL    = 5'd10,
      OP_MULH   = 5'd11,
      OP_MULHU  = 5'd12,
      OP_MULHSU = 5'd13,
      OP_DIV    = 5'd14,
      OP_DIVU   = 5'd15,
      OP_REM    = 5'd16,
      OP_REMU   = 5'd17,
      OP_COPYB  = 5'd18
   } op_type;

   typedef struct packed {
      logic [ModeBits-1:0] mode;
      logic [WordBits-1:0] operand_a;
      logic [WordBits-1:0] operand_b;
      logic [TagBits-1:0]  dest_index;
   } req_type;

   typedef struct packed {
      logic [WordBits-1:0] result_value;
      logic [TagBits-1:0]  dest_tag;
   } rsp_type;

   // work carried from cell to cell
   typedef struct packed {
      logic                valid;
      logic                is_div;     // divide/remainder uses the cells
      logic                want_rem;
      logic                neg_q;
      logic                neg_r;
      logic                div_zero;
      logic [WordBits-1:0] orig_a;
      logic [WordBits-1:0] divisor;    // magnitude
      logic [WordBits-1:0] quot;       // shifts in dividend, out quotient
      logic [WordBits-1:0] rem;
      logic [WordBits-1:0] early;      // result of non-divide ops
      logic [TagBits-1:0]  tag;
   } cell_type;

endpackage
`default_nettype wire

// ===== sv/rv32im_integer_alu.sv =====
// ----------------------------------------------------------------------------
// rv32im_integer_alu: RV32IM integer execute unit
// Decode stage, a chain of divide cells, and a result stage.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | mode, operand_a, operand_b, dest_index
//  rsp_    | out       | result_value, dest_tag
//
// One item per cycle enters while the chain advances; every item goes through
// the decode stage, all divide cells and the result stage. Reset clears the
// valid bits of all stages. A stalled rsp_ freezes the whole chain; req_ready
// follows rsp_ready while the result register holds an item.
`default_nettype none
module rv32im_integer_alu #(
   parameter int unsigned DIV_BITS = rvalu_pkg::DivBitsPerCell
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire rvalu_pkg::req_type   req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rvalu_pkg::rsp_type        rsp_data
);
   localparam int unsigned W = rvalu_pkg::WordBits;
   localparam int unsigned NCells = W / DIV_BITS;

   rvalu_pkg::cell_type chain [NCells+1];
   logic advance;
   logic req_fire;
   logic [W-1:0] q_fix, r_fix;
   rvalu_pkg::cell_type last;
   rvalu_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff;

   // advance whenever the result slot is empty or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_fire  = req_valid && req_ready;

   rvalu_front u_front (
      .clock, .reset, .advance, .req_fire,
      .req(req_data), .cell_out(chain[0])
   );

   for (genvar g = 0; g < NCells; g++) begin : g_cell
      rvalu_cell #(.DIV_BITS(DIV_BITS)) u_cell (
         .clock, .reset, .advance,
         .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   assign last  = chain[NCells];
   assign q_fix = last.neg_q ? (W'(0) - last.quot) : last.quot;
   assign r_fix = last.neg_r ? (W'(0) - last.rem) : last.rem;

   always_comb begin
      out_in.dest_tag = last.tag;
      if (!last.is_div) begin
         out_in.result_value = last.early;
      end else if (last.div_zero) begin
         out_in.result_value = last.want_rem ? last.orig_a : '1;
      end else begin
         out_in.result_value = last.want_rem ? r_fix : q_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      advance && last.valid && last.is_div && last.div_zero && !last.want_rem
      |=> rsp_data.result_value == '1)
      else $error("divide by zero result wrong");
endmodule
`default_nettype wire

// ===== sv/rvalu_cell.sv =====
// ----------------------------------------------------------------------------
// rvalu_cell: one divide cell of the execute chain
// Resolves DIV_BITS restoring-division quotient bits and registers the item.
// ----------------------------------------------------------------------------
`default_nettype none
module rvalu_cell #(
   parameter int unsigned DIV_BITS = rvalu_pkg::DivBitsPerCell
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire rvalu_pkg::cell_type cell_in,
   output rvalu_pkg::cell_type     cell_out
);
   rvalu_pkg::cell_type cell_ff;
   rvalu_pkg::cell_type cell_in_c;

   always_comb begin
      logic [rvalu_pkg::WordBits:0] trial;
      cell_in_c = cell_in;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {cell_in_c.rem, cell_in_c.quot[rvalu_pkg::WordBits-1]}
                 - {1'b0, cell_in_c.divisor};
         if (!trial[rvalu_pkg::WordBits]) begin
            cell_in_c.rem  = trial[rvalu_pkg::WordBits-1:0];
            cell_in_c.quot = {cell_in_c.quot[rvalu_pkg::WordBits-2:0], 1'b1};
         end else begin
            cell_in_c.rem  = {cell_in_c.rem[rvalu_pkg::WordBits-2:0],
                              cell_in_c.quot[rvalu_pkg::WordBits-1]};
            cell_in_c.quot = {cell_in_c.quot[rvalu_pkg::WordBits-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_c;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// ===== sv/rvalu_front.sv =====
// ----------------------------------------------------------------------------
// rvalu_front: decode stage of the execute chain
// Computes the non-divide ops and products, prepares divide operands.
// ----------------------------------------------------------------------------
`default_nettype none
module rvalu_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               req_fire,
   input  wire rvalu_pkg::req_type req,
   output rvalu_pkg::cell_type     cell_out
);
   localparam int unsigned W = rvalu_pkg::WordBits;

   rvalu_pkg::cell_type cell_ff;
   rvalu_pkg::cell_type cell_in;
   logic [W-1:0] a, b, ma, mb;
   logic [4:0]   sh;
   logic [2*W-1:0] prod;
   logic [W-1:0]   hu;

   assign a  = req.operand_a;
   assign b  = req.operand_b;
   assign sh = b[4:0];
   assign ma = a[W-1] ? (W'(0) - a) : a;
   assign mb = b[W-1] ? (W'(0) - b) : b;
   assign prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
   assign hu   = prod[2*W-1:W];

   always_comb begin
      logic sgn;
      sgn = (req.mode == rvalu_pkg::OP_DIV) || (req.mode == rvalu_pkg::OP_REM);
      cell_in          = '0;
      cell_in.valid    = req_fire;
      cell_in.tag      = req.dest_index;
      cell_in.orig_a   = a;
      cell_in.is_div   = (req.mode == rvalu_pkg::OP_DIV) || (req.mode == rvalu_pkg::OP_DIVU)
                      || (req.mode == rvalu_pkg::OP_REM) || (req.mode == rvalu_pkg::OP_REMU);
      cell_in.want_rem = (req.mode == rvalu_pkg::OP_REM) || (req.mode == rvalu_pkg::OP_REMU);
      cell_in.div_zero = (b == '0);
      cell_in.divisor  = sgn ? mb : b;
      cell_in.quot     = sgn ? ma : a;
      cell_in.neg_q    = sgn && (a[W-1] ^ b[W-1]);
      cell_in.neg_r    = sgn && a[W-1];
      unique case (req.mode)
         rvalu_pkg::OP_ADD:    cell_in.early = a + b;
         rvalu_pkg::OP_SUB:    cell_in.early = a - b;
         rvalu_pkg::OP_SLL:    cell_in.early = a << sh;
         rvalu_pkg::OP_SLT:    cell_in.early = W'($signed(a) < $signed(b));
         rvalu_pkg::OP_SLTU:   cell_in.early = W'(a < b);
         rvalu_pkg::OP_XOR:    cell_in.early = a ^ b;
         rvalu_pkg::OP_OR:     cell_in.early = a | b;
         rvalu_pkg::OP_AND:    cell_in.early = a & b;
         rvalu_pkg::OP_SRL:    cell_in.early = a >> sh;
         rvalu_pkg::OP_SRA:    cell_in.early = W'($signed(a) >>> sh);
         rvalu_pkg::OP_MUL:    cell_in.early = prod[W-1:0];
         rvalu_pkg::OP_MULH:   cell_in.early = hu - (a[W-1] ? b : '0) - (b[W-1] ? a : '0);
         rvalu_pkg::OP_MULHU:  cell_in.early = hu;
         rvalu_pkg::OP_MULHSU: cell_in.early = hu - (a[W-1] ? b : '0);
         rvalu_pkg::OP_COPYB:  cell_in.early = b;
         default:              cell_in.early = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire
